// ===== src/lear_pkg.sv =====
// Package for the LE advertising report parser.
// Holds the parse phase enum, result kind and error codes, and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lear_pkg;

  // Number of advertiser address bytes in one report
  localparam int unsigned ADDR_BYTES = 6;

  // Subevent code of an advertising report after reset
  localparam logic [7:0] SUBEVENT_RESET = 8'h02;

  // Parse phase
  typedef enum logic [3:0] {
    PH_SUBEVENT = 4'd0,
    PH_COUNT    = 4'd1,
    PH_EVTYPE   = 4'd2,
    PH_ADDRTYPE = 4'd3,
    PH_ADDR     = 4'd4,
    PH_LEN      = 4'd5,
    PH_DATA     = 4'd6,
    PH_RSSI     = 4'd7,
    PH_SURPLUS  = 4'd8,
    PH_DRAIN    = 4'd9
  } phase_t;

  // Result kind
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic ERR_SUBEVENT  = 1'b0;
  localparam logic ERR_UNDERFLOW = 1'b1;

  // One result item
  typedef struct packed {
    logic [1:0]                kind;
    logic [7:0]                data_byte;
    logic [7:0]                evt_type;
    logic [7:0]                addr_type;
    logic [8*ADDR_BYTES-1:0]   device_address;
    logic [7:0]                data_length;
    logic signed [7:0]         rssi;
    logic                      final_report;
    logic                      error_code;
    logic                      last_result;
  } res_t;

  // Queue write request: up to two results per input item
  typedef struct packed {
    logic en0;
    logic en1;
  } qwr_t;

endpackage

`default_nettype wire

// ===== src/lear_core.sv =====
// Parse core: phase machine, held report fields and result formation.
// Turns one accepted parameter byte into at most two results in the same cycle.
// Depends on lear_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lear_core import lear_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  input  wire logic [7:0] expected,
  output qwr_t            wr,
  output res_t            wr_data0,
  output res_t            wr_data1
);

  phase_t                  phase_r, phase_nxt;
  logic [2:0]              idx_r, idx_nxt;
  logic [7:0]              data_left_r, data_left_nxt;
  logic [7:0]              reports_left_r, reports_left_nxt;
  logic [7:0]              ev_type_r, ev_type_nxt;
  logic [7:0]              addr_type_r, addr_type_nxt;
  logic [8*ADDR_BYTES-1:0] addr_r, addr_nxt;
  logic [7:0]              len_r, len_nxt;

  logic       complete;
  logic       no_check;
  logic       underflow;
  logic [7:0] data_dec;
  logic [7:0] reports_dec;
  logic       v0;
  res_t       r0;
  res_t       r_err;

  assign data_dec    = data_left_r - 8'd1;
  assign reports_dec = reports_left_r - 8'd1;

  // Next phase and held fields
  always_comb begin
    phase_nxt        = phase_r;
    idx_nxt          = idx_r;
    data_left_nxt    = data_left_r;
    reports_left_nxt = reports_left_r;
    ev_type_nxt      = ev_type_r;
    addr_type_nxt    = addr_type_r;
    addr_nxt         = addr_r;
    len_nxt          = len_r;
    complete         = 1'b0;
    no_check         = 1'b0;
    if (in_fire) begin
      case (phase_r)
        PH_SUBEVENT: begin
          if (in_byte != expected) begin
            phase_nxt = PH_DRAIN;
            no_check  = 1'b1;
          end else begin
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          reports_left_nxt = in_byte;
          if (in_byte == 8'd0) begin
            phase_nxt = PH_SURPLUS;
            complete  = 1'b1;
          end else begin
            phase_nxt = PH_EVTYPE;
          end
        end
        PH_EVTYPE: begin
          ev_type_nxt = in_byte;
          phase_nxt   = PH_ADDRTYPE;
        end
        PH_ADDRTYPE: begin
          addr_type_nxt = in_byte;
          addr_nxt      = '0;
          idx_nxt       = 3'd0;
          phase_nxt     = PH_ADDR;
        end
        PH_ADDR: begin
          // Merge the byte into its address lane
          for (int i = 0; i < ADDR_BYTES; i++) begin
            if (idx_r == 3'(i)) begin
              addr_nxt[8*i +: 8] = addr_r[8*i +: 8] | in_byte;
            end
          end
          if (idx_r >= 3'(ADDR_BYTES - 1)) begin
            idx_nxt   = 3'd0;
            phase_nxt = PH_LEN;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_LEN: begin
          len_nxt       = in_byte;
          data_left_nxt = in_byte;
          phase_nxt     = (in_byte == 8'd0) ? PH_RSSI : PH_DATA;
        end
        PH_DATA: begin
          data_left_nxt = data_dec;
          if (data_dec == 8'd0) begin
            phase_nxt = PH_RSSI;
          end
        end
        PH_RSSI: begin
          reports_left_nxt = reports_dec;
          if (reports_dec == 8'd0) begin
            phase_nxt = PH_SURPLUS;
            complete  = 1'b1;
          end else begin
            phase_nxt = PH_EVTYPE;
          end
        end
        PH_SURPLUS: begin
          complete = 1'b1;
        end
        default: begin
          no_check = 1'b1;
        end
      endcase
      // Return to the start on the end flag
      if (in_end) begin
        phase_nxt        = PH_SUBEVENT;
        idx_nxt          = 3'd0;
        data_left_nxt    = 8'd0;
        reports_left_nxt = 8'd0;
      end
    end
  end

  assign underflow = in_fire && in_end && !complete && !no_check;

  // Result formation
  always_comb begin
    v0 = 1'b0;
    r0 = '0;
    r_err = '0;
    r_err.kind        = KIND_ERROR;
    r_err.error_code  = ERR_UNDERFLOW;
    r_err.last_result = 1'b1;
    if (in_fire) begin
      case (phase_r)
        PH_SUBEVENT: begin
          if (in_byte != expected) begin
            v0            = 1'b1;
            r0.kind       = KIND_ERROR;
            r0.error_code = ERR_SUBEVENT;
          end
        end
        PH_DATA: begin
          v0           = 1'b1;
          r0.kind      = KIND_DATA;
          r0.data_byte = in_byte;
        end
        PH_RSSI: begin
          v0                = 1'b1;
          r0.kind           = KIND_REPORT;
          r0.evt_type       = ev_type_r;
          r0.addr_type      = addr_type_r;
          r0.device_address = addr_r;
          r0.data_length    = len_r;
          r0.rssi           = in_byte;
          r0.final_report   = (reports_left_r == 8'd1);
        end
        default: begin
          v0 = 1'b0;
        end
      endcase
    end
    r0.last_result = !underflow;
  end

  // Drive the queue: the first slot takes whichever result comes first
  assign wr.en0   = v0 || underflow;
  assign wr.en1   = v0 && underflow;
  assign wr_data0 = v0 ? r0 : r_err;
  assign wr_data1 = r_err;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SUBEVENT;
      idx_r          <= 3'd0;
      data_left_r    <= 8'd0;
      reports_left_r <= 8'd0;
      ev_type_r      <= 8'd0;
      addr_type_r    <= 8'd0;
      addr_r         <= '0;
      len_r          <= 8'd0;
    end else begin
      phase_r        <= phase_nxt;
      idx_r          <= idx_nxt;
      data_left_r    <= data_left_nxt;
      reports_left_r <= reports_left_nxt;
      ev_type_r      <= ev_type_nxt;
      addr_type_r    <= addr_type_nxt;
      addr_r         <= addr_nxt;
      len_r          <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/lear_rq.sv =====
// Result queue: small register queue taking up to two results a cycle, one out.
// Depends on lear_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lear_rq import lear_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire qwr_t wr,
  input  wire res_t wr_data0,
  input  wire res_t wr_data1,
  output logic      room2,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output res_t      rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t            entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wp1;
  logic [PW-1:0]   wp2;
  logic [PW-1:0]   rp1;
  logic            pop;

  // Wrapped pointer steps
  assign wp1 = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
  assign wp2 = (wp1 == PW'(DEPTH - 1)) ? '0 : wp1 + PW'(1);
  assign rp1 = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);

  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;
  assign room2    = (count_r <= CW'(DEPTH - 2));

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr.en1 ? wp2 : (wr.en0 ? wp1 : wr_ptr_r);
    rd_ptr_nxt = pop ? rp1 : rd_ptr_r;
    count_nxt  = count_r + CW'(wr.en0) + CW'(wr.en1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (wr.en0) begin
      entry_r[wr_ptr_r] <= wr_data0;
    end
    if (wr.en1) begin
      entry_r[wp1] <= wr_data1;
    end
  end

endmodule

`default_nettype wire

// ===== src/le_advertising_report_parser.sv =====
// LE advertising report parser, top level. Uses lear_pkg, lear_core, lear_rq.
// Results are registered in the result queue and shown from its head.
// Throughput: one byte per cycle while in_tready is high; a data or RSSI byte that
// closes an event early yields two results, which leave the queue in order.
// in_tready is high while the result queue has room for two results.
// Reset (rst_n low, synchronous): queue emptied, parser waits for a subevent code,
// expected subevent set to 2.
`timescale 1ns / 1ps
`default_nettype none

module le_advertising_report_parser import lear_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Parameter bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] param_byte
  input  wire logic        in_tlast,   // end_of_event
  // Results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] data_byte, [15:8] report type, [23:16] advertiser address kind,
  // [71:24] device_address, [79:72] data_length, [87:80] rssi,
  // [88] final_report, [89] error_code, [95:90] zero
  output logic [95:0]      out_tdata,
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,  // last_result
  // Configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data // expected_subevent
);

  logic [7:0] expected_r;
  logic       in_fire;
  qwr_t       wr;
  res_t       wr_data0;
  res_t       wr_data1;
  res_t       head;
  logic       room2;

  // Hold the expected subevent code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= SUBEVENT_RESET;
    end else if (cfg_wr_en) begin
      expected_r <= cfg_wr_data;
    end
  end

  assign in_tready = room2;
  assign in_fire   = in_tvalid && in_tready;

  lear_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .expected (expected_r),
    .wr       (wr),
    .wr_data0 (wr_data0),
    .wr_data1 (wr_data1)
  );

  lear_rq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .wr_data0 (wr_data0),
    .wr_data1 (wr_data1),
    .room2    (room2),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  // Pack the head result
  assign out_tdata = {6'd0, head.error_code, head.final_report, head.rssi,
                      head.data_length, head.device_address, head.addr_type,
                      head.evt_type, head.data_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_result;

  // Nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // Back-pressure only when results are waiting
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result queue");

  // A second result only follows a first one
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en1 |-> wr.en0 && wr_data1.kind == KIND_ERROR)
    else $error("second result without first");

  // An underflow error always closes the results of its byte
  a_underflow_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERROR && out_tdata[89] |-> out_tlast)
    else $error("underflow error not marked last");

endmodule

`default_nettype wire

// ===== verif/tb_le_advertising_report_parser.sv =====
// Testbench for le_advertising_report_parser: streams LE meta event parameter bytes and
// checks every result item against a cycle-free parse of the same bytes.
// Depends on lear_pkg and the le_advertising_report_parser RTL only.
`timescale 1ns / 1ps

module tb_le_advertising_report_parser;
  import lear_pkg::*;

  // One parameter byte with its end-of-event flag
  typedef struct packed {
    logic [7:0] value;
    logic       eoe;
  } param_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  le_advertising_report_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Bytes waiting to be offered, and results the parser still owes
  param_item_t bytes_to_send[$];
  res_t        results_due[$];
  param_item_t next_byte;

  // Shadow of the parser state and its subevent register
  logic [7:0]  cur_subevent;
  phase_t      parse_phase;
  logic [2:0]  addr_idx;
  logic [7:0]  data_left;
  logic [7:0]  reports_left;
  logic [7:0]  held_evtype;
  logic [7:0]  held_addrtype;
  logic [47:0] held_addr;
  logic [7:0]  held_len;

  int send_idle_pct;
  int recv_idle_pct;
  logic rx_hold;
  logic in_taken;

  int bytes_queued;
  int bytes_accepted;
  int results_seen;
  int data_seen;
  int reports_seen;
  int errors_seen;
  int mismatches;
  int settings_used;

  // Print a line for each of the first 40 mismatches, and count every mismatch
  task automatic flag_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    if (mismatches < 40)
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Advance the shadow parser by one accepted byte and queue the results it causes
  task automatic parse_param_byte(input logic [7:0] b, input logic eoe);
    res_t caused[$];
    res_t r;
    bit   may_end;
    bit   no_underflow;
    may_end = 0;
    no_underflow = 0;
    case (parse_phase)
      PH_SUBEVENT: begin
        if (b != cur_subevent) begin
          r = '0;
          r.kind = KIND_ERROR;
          r.error_code = ERR_SUBEVENT;
          caused.push_back(r);
          parse_phase = PH_DRAIN;
          no_underflow = 1;
        end else begin
          parse_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        reports_left = b;
        if (b == 8'd0) begin
          parse_phase = PH_SURPLUS;
          may_end = 1;
        end else begin
          parse_phase = PH_EVTYPE;
        end
      end
      PH_EVTYPE: begin
        held_evtype = b;
        parse_phase = PH_ADDRTYPE;
      end
      PH_ADDRTYPE: begin
        held_addrtype = b;
        held_addr = '0;
        addr_idx = '0;
        parse_phase = PH_ADDR;
      end
      PH_ADDR: begin
        held_addr[8*addr_idx +: 8] = b;
        if (addr_idx == 3'(ADDR_BYTES - 1)) begin
          addr_idx = '0;
          parse_phase = PH_LEN;
        end else begin
          addr_idx = addr_idx + 3'd1;
        end
      end
      PH_LEN: begin
        held_len = b;
        data_left = b;
        parse_phase = (b == 8'd0) ? PH_RSSI : PH_DATA;
      end
      PH_DATA: begin
        r = '0;
        r.kind = KIND_DATA;
        r.data_byte = b;
        caused.push_back(r);
        data_left = data_left - 8'd1;
        if (data_left == 8'd0) parse_phase = PH_RSSI;
      end
      PH_RSSI: begin
        r = '0;
        r.kind = KIND_REPORT;
        r.evt_type = held_evtype;
        r.addr_type = held_addrtype;
        r.device_address = held_addr;
        r.data_length = held_len;
        r.rssi = b;
        r.final_report = (reports_left == 8'd1);
        caused.push_back(r);
        reports_left = reports_left - 8'd1;
        if (reports_left == 8'd0) begin
          parse_phase = PH_SURPLUS;
          may_end = 1;
        end else begin
          parse_phase = PH_EVTYPE;
        end
      end
      PH_SURPLUS: may_end = 1;
      default: no_underflow = 1;
    endcase

    // Close the event; flag underflow if the announced reports are not done
    if (eoe) begin
      if (!may_end && !no_underflow) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = ERR_UNDERFLOW;
        caused.push_back(r);
      end
      parse_phase = PH_SUBEVENT;
      addr_idx = '0;
      data_left = '0;
      reports_left = '0;
    end

    if (caused.size() > 0) caused[caused.size()-1].last_result = 1'b1;
    foreach (caused[i]) results_due.push_back(caused[i]);
  endtask

  // Compare one result item, field by field, with the oldest one owed
  task automatic check_result();
    res_t want;
    if (results_due.size() == 0) begin
      flag_mismatch("result with none owed", out_tdata[47:0], '0);
      return;
    end
    want = results_due.pop_front();
    results_seen++;
    case (want.kind)
      KIND_DATA:   data_seen++;
      KIND_REPORT: reports_seen++;
      default:     errors_seen++;
    endcase
    if (out_tuser != want.kind)
      flag_mismatch("kind", 48'(out_tuser), 48'(want.kind));
    if (out_tdata[7:0] != want.data_byte)
      flag_mismatch("data_byte", 48'(out_tdata[7:0]), 48'(want.data_byte));
    if (out_tdata[15:8] != want.evt_type)
      flag_mismatch("evt_type", 48'(out_tdata[15:8]), 48'(want.evt_type));
    if (out_tdata[23:16] != want.addr_type)
      flag_mismatch("addr_type", 48'(out_tdata[23:16]), 48'(want.addr_type));
    if (out_tdata[71:24] != want.device_address)
      flag_mismatch("device_address", out_tdata[71:24], want.device_address);
    if (out_tdata[79:72] != want.data_length)
      flag_mismatch("data_length", 48'(out_tdata[79:72]), 48'(want.data_length));
    if (out_tdata[87:80] != $unsigned(want.rssi))
      flag_mismatch("rssi", 48'(out_tdata[87:80]), 48'($unsigned(want.rssi)));
    if (out_tdata[88] != want.final_report)
      flag_mismatch("final_report", 48'(out_tdata[88]), 48'(want.final_report));
    if (out_tdata[89] != want.error_code)
      flag_mismatch("error_code", 48'(out_tdata[89]), 48'(want.error_code));
    if (out_tlast != want.last_result)
      flag_mismatch("last_result", 48'(out_tlast), 48'(want.last_result));
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eoe);
    bytes_to_send.push_back('{value: b, eoe: eoe});
    bytes_queued++;
  endtask

  // Build one event with random content; most are well formed, some are cut short,
  // carry trailing bytes, use a wrong subevent, or are plain noise
  task automatic queue_random_event();
    param_item_t ev[$];
    int style;
    int n_rep;
    int n_built;
    int len;
    int pick;
    int keep;
    style = $urandom_range(99);
    if (style < 5) begin
      repeat ($urandom_range(1, 6)) ev.push_back('{value: 8'($urandom), eoe: 1'b0});
    end else begin
      if (style < 13) ev.push_back('{value: cur_subevent ^ 8'($urandom_range(1, 255)),
                                     eoe: 1'b0});
      else ev.push_back('{value: cur_subevent, eoe: 1'b0});
      pick = $urandom_range(99);
      if (pick < 8)       n_rep = 0;
      else if (pick < 92) n_rep = $urandom_range(1, 3);
      else                n_rep = $urandom_range(4, 255);
      ev.push_back('{value: 8'(n_rep), eoe: 1'b0});
      n_built = (n_rep > 3) ? $urandom_range(0, 2) : n_rep;
      repeat (n_built) begin
        repeat (ADDR_BYTES + 2) ev.push_back('{value: 8'($urandom), eoe: 1'b0});
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(0, 4);
        else if (pick < 96) len = $urandom_range(5, 20);
        else                len = $urandom_range(21, 255);
        ev.push_back('{value: 8'(len), eoe: 1'b0});
        repeat (len + 1) ev.push_back('{value: 8'($urandom), eoe: 1'b0});
      end
      if ($urandom_range(99) < 20)
        repeat ($urandom_range(1, 4)) ev.push_back('{value: 8'($urandom), eoe: 1'b0});
      // Cut the event short now and then
      if (n_rep > 3 || $urandom_range(99) < 15) begin
        keep = $urandom_range(1, ev.size());
        while (ev.size() > keep) void'(ev.pop_back());
      end
    end
    ev[ev.size()-1].eoe = 1'b1;
    foreach (ev[i]) queue_byte(ev[i].value, ev[i].eoe);
  endtask

  // Wait until every byte is taken and every owed result has come, then settle
  task automatic wait_idle();
    wait (bytes_accepted == bytes_queued);
    wait (results_due.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_subevent(input logic [7:0] code);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_subevent = code;
    settings_used++;
  endtask

  task automatic run_random_phase(input logic [7:0] code, input int n_bytes);
    int target;
    wait_idle();
    write_subevent(code);
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) queue_random_event();
  endtask

  always #6 clk = ~clk;

  // Offer bytes at the falling edge; hold the current one until it is taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = bytes_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_byte.value;
        in_tlast <= next_byte.eoe;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or fully during a long hold
  always @(negedge clk) begin
    if (rst_n) out_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_param_byte(in_tdata, in_tlast);
        bytes_accepted++;
      end
      if (out_tvalid && out_tready) check_result();
    end
  end

  // Hold off the result side for long stretches so the input backs up
  initial begin
    rx_hold = 1'b0;
    wait (bytes_accepted >= 300);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (150) @(negedge clk);
    rx_hold <= 1'b0;
    wait (bytes_accepted >= 1300);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (200) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Give up after a generous bound
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_taken = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 53;
    bytes_queued = 0;
    bytes_accepted = 0;
    results_seen = 0;
    data_seen = 0;
    reports_seen = 0;
    errors_seen = 0;
    mismatches = 0;
    settings_used = 1;
    cur_subevent = SUBEVENT_RESET;
    parse_phase = PH_SUBEVENT;
    addr_idx = '0;
    data_left = '0;
    reports_left = '0;
    held_evtype = '0;
    held_addrtype = '0;
    held_addr = '0;
    held_len = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one report with extreme fields, one data byte, surplus byte at the end
    queue_byte(SUBEVENT_RESET, 1'b0);
    queue_byte(8'd1, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    repeat (ADDR_BYTES) queue_byte(8'hFF, 1'b0);
    queue_byte(8'd1, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h55, 1'b1);
    // Wrong subevent, then a byte that must be ignored
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // Zero reports, ending on the count byte
    queue_byte(SUBEVENT_RESET, 1'b0);
    queue_byte(8'd0, 1'b1);
    // Early end on the count byte
    queue_byte(SUBEVENT_RESET, 1'b0);
    queue_byte(8'd3, 1'b1);
    // Early end on the subevent byte itself
    queue_byte(SUBEVENT_RESET, 1'b1);

    // Random phases under changing subevent codes and stall patterns
    run_random_phase(8'h00, 390);
    run_random_phase(8'hFF, 390);
    wait_idle();
    send_idle_pct = 53;
    recv_idle_pct = 24;
    run_random_phase(8'h3E, 390);
    run_random_phase(8'($urandom), 390);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(SUBEVENT_RESET, 390);

    wait_idle();
    repeat (10) @(negedge clk);
    $display("Run covered %0d parameter bytes and %0d results under %0d subevent codes.",
             bytes_accepted, results_seen, settings_used);
    $display("Results: %0d data bytes, %0d reports, %0d errors; %0d mismatches.",
             data_seen, reports_seen, errors_seen, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
